FILE: rtl/timq_pkg.sv
// timed event min queue: shared types, widths and codes
// used by timq_alu and the top level; depends on nothing

package timq_pkg;

	localparam int QUEUE_DEPTH_DEF = 1024;

	localparam int CMD_W  = 3;
	localparam int ID_W   = 31;
	localparam int TIME_W = 48;
	localparam int SLOT_W = 10;
	localparam int OCC_W  = 11;

	localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 3'd0,
		CMD_PUSH    = 3'd1,
		CMD_CHECK   = 3'd2,
		CMD_ADVANCE = 3'd3,
		CMD_REMOVE  = 3'd4,
		CMD_SHIFT   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NONE   = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                      cmd;
		logic [ID_W-1:0]           event_id;
		logic signed [TIME_W-1:0]  event_time;
		logic [SLOT_W-1:0]         slot;
		logic signed [TIME_W-1:0]  shift_amount;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic [ID_W-1:0]           out_id;
		logic signed [TIME_W-1:0]  out_time;
		logic [OCC_W-1:0]          occupancy;
	} rsp_t;

	// one stored table entry
	typedef struct packed {
		logic signed [TIME_W-1:0]  due;
		logic [ID_W-1:0]           id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/timq_ram.sv
// generic single-write, single-read ram with registered read data
// no package dependency

module timq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/timq_alu.sv
// shared time unit: signed compare and saturating add of two due times
// depends on timq_pkg for the time width and limits

module timq_alu (
	input  logic signed [timq_pkg::TIME_W-1:0] a,
	input  logic signed [timq_pkg::TIME_W-1:0] b,
	output logic                               less,
	output logic signed [timq_pkg::TIME_W-1:0] sum_sat
);

	logic [timq_pkg::TIME_W:0] sum_w;

	assign less  = a < b;
	assign sum_w = {a[timq_pkg::TIME_W-1], a} + {b[timq_pkg::TIME_W-1], b};

	always_comb begin
		// top two bits differ: the sum left the 48-bit range
		if (sum_w[timq_pkg::TIME_W] != sum_w[timq_pkg::TIME_W-1]) begin
			sum_sat = sum_w[timq_pkg::TIME_W] ? timq_pkg::TIME_MIN : timq_pkg::TIME_MAX;
		end else begin
			sum_sat = sum_w[timq_pkg::TIME_W-1:0];
		end
	end

endmodule

FILE: rtl/timed_event_min_queue_top.sv
// timed event min queue: top level, command sequencer and entry table
// depends on timq_pkg, timq_ram and timq_alu
//
// usage
//  - commands enter on req (req_valid / req_stall), one result per command
//    leaves on rsp (rsp_valid / rsp_stall); a transfer happens at a rising
//    edge with valid high and stall low
//  - req_stall is high whenever a command is in progress: one command at a
//    time, the next is taken once the result sits in the output register
//  - clear, push, a failed check/advance/remove, a shift of an empty
//    table and unused codes go from S_EXEC straight to S_DONE
//  - a pop (check, advance) or a remove reads the taken and the last
//    entry, moves the last one into the hole, then rescans the entries
//    left: the rescan streams the table through the one ram read port and
//    the shared compare unit, one entry a cycle
//  - a shift reads each entry, passes it through the saturating adder and
//    writes it back, one a cycle; worst case is one table pass per command
//  - if the receiver stalls, the result holds in the output register and
//    a finished command waits for it before giving its result
//  - reset empties the table at once; entry storage itself is not cleared,
//    entries at or above the fill count are never read

module timed_event_min_queue_top #(
	parameter int QUEUE_DEPTH = timq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  timq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output timq_pkg::rsp_t rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = (CW > timq_pkg::SLOT_W) ? CW : timq_pkg::SLOT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_TAKE_RD,
		S_TAKE_LAST,
		S_TAKE_MOVE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t                              state_q;
	timq_pkg::req_t                      req_q;
	timq_pkg::status_t                   st_q;
	timq_pkg::rsp_t                      rsp_q;
	logic                                rsp_valid_q;
	logic [CW-1:0]                       fill_q;
	logic signed [timq_pkg::TIME_W-1:0]  emin_due_q;
	logic [AW-1:0]                       emin_slot_q;
	logic [AW-1:0]                       pos_q;
	logic [timq_pkg::ID_W-1:0]           tk_id_q;
	logic signed [timq_pkg::TIME_W-1:0]  tk_time_q;
	logic [CW-1:0]                       idx_q;
	// read pipeline tag: data of entry pidx_s1 is on the ram output
	logic                                pend_s1;
	logic [CW-1:0]                       pidx_s1;

	// ram and shared unit hookup
	logic                                ram_we;
	logic [AW-1:0]                       ram_waddr;
	timq_pkg::entry_t                    ram_wdata;
	logic                                ram_re;
	logic [AW-1:0]                       ram_raddr;
	logic [timq_pkg::ENTRY_W-1:0]        ram_rdata;
	timq_pkg::entry_t                    rd_ent;
	logic signed [timq_pkg::TIME_W-1:0]  alu_a;
	logic signed [timq_pkg::TIME_W-1:0]  alu_b;
	logic                                alu_less;
	logic signed [timq_pkg::TIME_W-1:0]  alu_sum;

	// derived control values
	logic [CW-1:0]                       last_c;
	logic                                room_c;
	logic                                slot_bad_c;
	logic [SW-1:0]                       slot_x_c;
	logic                                pos_moves_c;
	logic                                pend_last_c;

	assign rd_ent      = timq_pkg::entry_t'(ram_rdata);
	assign last_c      = fill_q - CW'(1);
	assign room_c      = fill_q < CW'(QUEUE_DEPTH);
	assign slot_x_c    = SW'(req_q.slot);
	assign slot_bad_c  = slot_x_c >= SW'(fill_q);
	assign pos_moves_c = CW'(pos_q) < last_c;
	assign pend_last_c = pend_s1 && (pidx_s1 == last_c);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	timq_ram #(
		.WIDTH(timq_pkg::ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	timq_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.less   (alu_less),
		.sum_sat(alu_sum)
	);

	// ram port and shared unit operand selection per sequencer step
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = rd_ent;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		alu_a     = rd_ent.due;
		alu_b     = emin_due_q;
		unique case (state_q)
			S_EXEC: begin
				// push appends at the fill position
				ram_we          = (req_q.cmd == timq_pkg::CMD_PUSH) && room_c;
				ram_waddr       = fill_q[AW-1:0];
				ram_wdata.due   = req_q.event_time;
				ram_wdata.id    = req_q.event_id;
				alu_a           = req_q.event_time;
			end
			S_TAKE_RD: begin
				ram_re    = 1'b1;
				ram_raddr = pos_q;
			end
			S_TAKE_LAST: begin
				ram_re    = 1'b1;
				ram_raddr = last_c[AW-1:0];
			end
			S_TAKE_MOVE: begin
				// last entry fills the hole
				ram_we = pos_moves_c;
			end
			S_SCAN: begin
				ram_re = idx_q < fill_q;
			end
			S_SHIFT: begin
				ram_re        = idx_q < fill_q;
				ram_we        = pend_s1;
				ram_waddr     = pidx_s1[AW-1:0];
				ram_wdata.due = alu_sum;
				alu_b         = req_q.shift_amount;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			st_q        <= timq_pkg::ST_OK;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			fill_q      <= '0;
			emin_due_q  <= '0;
			emin_slot_q <= '0;
			pos_q       <= '0;
			tk_id_q     <= '0;
			tk_time_q   <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			pidx_s1     <= '0;
		end else begin
			// a result leaving while the next one loads is handled in S_DONE
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q     <= req;
						st_q      <= timq_pkg::ST_OK;
						tk_id_q   <= '0;
						tk_time_q <= '0;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					unique case (req_q.cmd)
						timq_pkg::CMD_CLEAR: begin
							fill_q      <= '0;
							emin_due_q  <= '0;
							emin_slot_q <= '0;
						end
						timq_pkg::CMD_PUSH: begin
							if (!room_c) begin
								st_q <= timq_pkg::ST_FULL;
							end else begin
								if (fill_q == '0 || alu_less) begin
									emin_due_q  <= req_q.event_time;
									emin_slot_q <= fill_q[AW-1:0];
								end
								fill_q <= fill_q + CW'(1);
							end
						end
						timq_pkg::CMD_CHECK, timq_pkg::CMD_ADVANCE: begin
							// nothing due: table empty, or for check the earliest time lies after the given time
							if (fill_q == '0 || CW'(emin_slot_q) >= fill_q ||
									(req_q.cmd == timq_pkg::CMD_CHECK && alu_less)) begin
								st_q <= timq_pkg::ST_NONE;
							end else begin
								pos_q   <= emin_slot_q;
								state_q <= S_TAKE_RD;
							end
						end
						timq_pkg::CMD_REMOVE: begin
							if (slot_bad_c) begin
								st_q <= timq_pkg::ST_BADPOS;
							end else begin
								pos_q   <= slot_x_c[AW-1:0];
								state_q <= S_TAKE_RD;
							end
						end
						timq_pkg::CMD_SHIFT: begin
							if (fill_q != '0) begin
								idx_q   <= '0;
								pend_s1 <= 1'b0;
								state_q <= S_SHIFT;
							end
						end
						default: begin
						end
					endcase
				end
				S_TAKE_RD: begin
					state_q <= S_TAKE_LAST;
				end
				S_TAKE_LAST: begin
					tk_id_q   <= rd_ent.id;
					tk_time_q <= rd_ent.due;
					state_q   <= S_TAKE_MOVE;
				end
				S_TAKE_MOVE: begin
					fill_q <= last_c;
					if (last_c == '0) begin
						emin_due_q <= '0;
						state_q    <= S_DONE;
					end else begin
						idx_q   <= '0;
						pend_s1 <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (ram_re) begin
						idx_q <= idx_q + CW'(1);
					end
					pend_s1 <= ram_re;
					pidx_s1 <= idx_q;
					// strict less: the lowest position wins a tie
					if (pend_s1 && (pidx_s1 == '0 || alu_less)) begin
						emin_due_q  <= rd_ent.due;
						emin_slot_q <= pidx_s1[AW-1:0];
					end
					if (pend_last_c) begin
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (ram_re) begin
						idx_q <= idx_q + CW'(1);
					end
					pend_s1 <= ram_re;
					pidx_s1 <= idx_q;
					// earliest position is kept, its time reloaded
					if (pend_s1 && pidx_s1[AW-1:0] == emin_slot_q) begin
						emin_due_q <= alu_sum;
					end
					if (pend_last_c) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status    <= st_q;
						rsp_q.out_id    <= tk_id_q;
						rsp_q.out_time  <= tk_time_q;
						rsp_q.occupancy <= timq_pkg::OCC_W'(fill_q);
						rsp_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// fill count never passes the table size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(QUEUE_DEPTH))
		else $error("fill count above table size");

	// between commands the earliest position points at a live entry
	a_emin_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && fill_q != '0) |-> (CW'(emin_slot_q) < fill_q))
		else $error("earliest position outside live entries");

	// table writes stay at or below the fill position
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) <= fill_q))
		else $error("table write beyond fill position");

	// only a successful pop or remove carries id and time
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != timq_pkg::ST_OK) |->
		(rsp_q.out_id == '0 && rsp_q.out_time == '0))
		else $error("result fields set on a failed command");

	// a full report only comes from a full table
	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) && rsp_q.status == timq_pkg::ST_FULL |->
		fill_q == CW'(QUEUE_DEPTH))
		else $error("full status on a table with room");

endmodule
